/* sv/sspc_pkg.sv */
// Shared types and constants for the servo status packet checker.
package sspc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 9;
  localparam int unsigned StatusW = 3;

  localparam logic [ByteW-1:0]  HdrMark   = 8'hFF;
  localparam logic [CountW-1:0] MinBytes  = 9'd6;
  localparam logic [CountW-1:0] LenOffset = 9'd4;
  localparam logic [CountW-1:0] SumStart  = 9'd2;
  localparam logic [CountW-1:0] CountMax  = 9'd511;

  // Byte positions captured from the packet
  localparam logic [CountW-1:0] PosId     = 9'd2;
  localparam logic [CountW-1:0] PosLength = 9'd3;
  localparam logic [CountW-1:0] PosError  = 9'd4;
  localparam logic [CountW-1:0] PosParam0 = 9'd5;
  localparam logic [CountW-1:0] PosParam1 = 9'd6;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK       = 3'd0,
    STATUS_SHORT    = 3'd1,
    STATUS_HEADER   = 3'd2,
    STATUS_CHECKSUM = 3'd3,
    STATUS_LENGTH   = 3'd4,
    STATUS_DEVICE   = 3'd5
  } status_t;

  // Result item, first field in the highest bits
  typedef struct packed {
    logic [CountW-1:0] packet_bytes;
    logic [ByteW-1:0]  param_high;
    logic [ByteW-1:0]  param_low;
    logic [ByteW-1:0]  error_bits;
    logic [ByteW-1:0]  servo_id;
    status_t           status;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);
  localparam int unsigned OutDataW = ((ResultW + 7) / 8) * 8;

endpackage

/* sv/servo_status_packet_checker.sv */
// Servo status packet checker: per-byte header, checksum, length and error checks.
//
// Channel  Dir  Handshake            Payload
// s_       in   s_tvalid/s_tready    s_tdata = rx_byte, s_tlast = last_byte
// m_       out  m_tvalid/m_tready    m_tdata = one result per packet
//
// One byte is accepted per cycle; the running sum, byte counter and captured
// fields update at the accept edge. The result of the last byte is loaded into
// the output register at that same edge and is offered from the next cycle on.
// The input stalls only while a result sits in the output register and m_tready
// is low; every byte, last or not, waits then.
// rst (synchronous, active high) clears packet state and drops m_tvalid.
module servo_status_packet_checker
  import sspc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [ByteW-1:0]    s_tdata,   // [7:0] rx_byte
  input  logic                s_tlast,   // last_byte
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata    // [2:0] status, [10:3] servo_id,
                                         // [18:11] error_bits, [26:19] param_low,
                                         // [34:27] param_high, [43:35] packet_bytes,
                                         // [47:44] zero
);

  logic [CountW-1:0] byte_count;
  logic [ByteW-1:0]  running_sum;
  logic              header_good;
  logic [ByteW-1:0]  length_field;
  logic [ByteW-1:0]  id_seen;
  logic [ByteW-1:0]  error_seen;
  logic [ByteW-1:0]  first_param;
  logic [ByteW-1:0]  second_param;
  result_t           result;

  logic              in_xfer;
  logic [CountW-1:0] byte_count_next;
  logic              header_good_next;
  logic [ByteW-1:0]  length_field_next;
  logic [ByteW-1:0]  id_seen_next;
  logic [ByteW-1:0]  error_seen_next;
  logic [ByteW-1:0]  first_param_next;
  logic [ByteW-1:0]  second_param_next;
  logic [CountW:0]   length_sum;
  result_t           result_next;

  // Accept while the output register is empty or being drained
  assign s_tready = !m_tvalid || m_tready;
  assign in_xfer  = s_tvalid && s_tready;

  // Fold the incoming byte into the captured fields
  always_comb begin
    byte_count_next   = (byte_count < CountMax) ? byte_count + 1'b1 : byte_count;
    header_good_next  = header_good && !((byte_count < SumStart) && (s_tdata != HdrMark));
    id_seen_next      = (byte_count == PosId)     ? s_tdata : id_seen;
    length_field_next = (byte_count == PosLength) ? s_tdata : length_field;
    error_seen_next   = (byte_count == PosError)  ? s_tdata : error_seen;
    first_param_next  = (byte_count == PosParam0) ? s_tdata : first_param;
    second_param_next = (byte_count == PosParam1) ? s_tdata : second_param;
    length_sum        = {2'b00, length_field_next} + {1'b0, LenOffset};
  end

  // Run the checks in priority order for the last byte
  always_comb begin
    result_next.packet_bytes = byte_count_next;
    result_next.param_high   = second_param_next;
    result_next.param_low    = first_param_next;
    result_next.error_bits   = error_seen_next;
    result_next.servo_id     = id_seen_next;
    if (byte_count_next < MinBytes) begin
      result_next.status = STATUS_SHORT;
    end else if (!header_good_next) begin
      result_next.status = STATUS_HEADER;
    end else if (~running_sum != s_tdata) begin
      result_next.status = STATUS_CHECKSUM;
    end else if ((byte_count_next == CountMax) ||
                 (length_sum != {1'b0, byte_count_next})) begin
      result_next.status = STATUS_LENGTH;
    end else if (error_seen_next != '0) begin
      result_next.status = STATUS_DEVICE;
    end else begin
      result_next.status = STATUS_OK;
    end
  end

  // Advance packet state; clear it after the last byte
  always_ff @(posedge clk) begin
    if (rst || (in_xfer && s_tlast)) begin
      byte_count   <= '0;
      running_sum  <= '0;
      header_good  <= 1'b1;
      length_field <= '0;
      id_seen      <= '0;
      error_seen   <= '0;
      first_param  <= '0;
      second_param <= '0;
    end else if (in_xfer) begin
      byte_count   <= byte_count_next;
      header_good  <= header_good_next;
      length_field <= length_field_next;
      id_seen      <= id_seen_next;
      error_seen   <= error_seen_next;
      first_param  <= first_param_next;
      second_param <= second_param_next;
      if (byte_count >= SumStart) begin
        running_sum <= running_sum + s_tdata;
      end
    end
  end

  // Hold the result until the downstream transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_xfer && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && s_tlast) begin
      result <= result_next;
    end
  end

  assign m_tdata = {{(OutDataW - ResultW){1'b0}}, result};

endmodule

/* tb/sv/servo_reply_monitor.sv */
// Monitor that predicts and checks status replies of the servo status packet checker.
module servo_reply_monitor
  import sspc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [ByteW-1:0]    s_tdata,
  input  logic                s_tlast,
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [OutDataW-1:0] m_tdata,
  output int                  mismatches,
  output int                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted packet state
  logic [CountW-1:0] rx_count;
  logic [ByteW-1:0]  sum_acc;
  logic              hdr_ok;
  logic [ByteW-1:0]  len_byte;
  logic [ByteW-1:0]  id_byte;
  logic [ByteW-1:0]  err_byte;
  logic [ByteW-1:0]  p0_byte;
  logic [ByteW-1:0]  p1_byte;

  result_t expected_replies[$];
  int      bad_replies = 0;
  int      reply_num = 0;

  task automatic clear_packet();
    rx_count = '0;
    sum_acc  = '0;
    hdr_ok   = 1'b1;
    len_byte = '0;
    id_byte  = '0;
    err_byte = '0;
    p0_byte  = '0;
    p1_byte  = '0;
  endtask

  // Advance the packet state by one byte; on the last byte queue the reply
  task automatic predict_status_reply(input logic [ByteW-1:0] b, input logic last);
    logic [CountW-1:0] idx;
    logic [CountW-1:0] n;
    result_t           r;
    idx = rx_count;
    if (idx < PosId && b != HdrMark) hdr_ok = 1'b0;
    if (idx == PosId)     id_byte  = b;
    if (idx == PosLength) len_byte = b;
    if (idx == PosError)  err_byte = b;
    if (idx == PosParam0) p0_byte  = b;
    if (idx == PosParam1) p1_byte  = b;
    if (rx_count != CountMax) rx_count = rx_count + 1'b1;
    if (!last) begin
      if (idx >= SumStart) sum_acc = sum_acc + b;
    end else begin
      n = rx_count;
      if (n < MinBytes)
        r.status = STATUS_SHORT;
      else if (!hdr_ok)
        r.status = STATUS_HEADER;
      else if (~sum_acc != b)
        r.status = STATUS_CHECKSUM;
      else if (n >= CountMax || ({1'b0, len_byte} + LenOffset) != n)
        r.status = STATUS_LENGTH;
      else if (err_byte != '0)
        r.status = STATUS_DEVICE;
      else
        r.status = STATUS_OK;
      r.servo_id     = id_byte;
      r.error_bits   = err_byte;
      r.param_low    = p0_byte;
      r.param_high   = p1_byte;
      r.packet_bytes = n;
      expected_replies.push_back(r);
      clear_packet();
    end
  endtask

  // Compare one reply transfer against the oldest prediction
  task automatic compare_reply(input result_t got);
    result_t want;
    reply_num++;
    if (expected_replies.size() == 0) begin
      bad_replies++;
      if (bad_replies <= 10)
        $display("reply %0d: unexpected, got status=%0d id=%02h", reply_num,
                 got.status, got.servo_id);
    end else begin
      want = expected_replies.pop_front();
      if (got.status != want.status || got.servo_id != want.servo_id ||
          got.error_bits != want.error_bits || got.param_low != want.param_low ||
          got.param_high != want.param_high ||
          got.packet_bytes != want.packet_bytes) begin
        bad_replies++;
        if (bad_replies <= 10) begin
          $display("reply %0d: expected status=%0d id=%02h err=%02h p0=%02h p1=%02h n=%0d",
                   reply_num, want.status, want.servo_id, want.error_bits,
                   want.param_low, want.param_high, want.packet_bytes);
          $display("reply %0d: actual   status=%0d id=%02h err=%02h p0=%02h p1=%02h n=%0d",
                   reply_num, got.status, got.servo_id, got.error_bits,
                   got.param_low, got.param_high, got.packet_bytes);
        end
      end
    end
  endtask

  // Check the output first so a same-edge prediction is never consumed early
  always @(posedge clk) begin
    if (rst) begin
      clear_packet();
      expected_replies.delete();
    end else begin
      if (m_tvalid && m_tready) compare_reply(result_t'(m_tdata[ResultW-1:0]));
      if (s_tvalid && s_tready) predict_status_reply(s_tdata, s_tlast);
    end
    mismatches  <= bad_replies;
    outstanding <= expected_replies.size();
  end

endmodule

/* tb/sv/tb_top.sv */
// Top of the testbench: clock, reset, packet stimulus, reply stalls and the verdict.
module tb_top;
  import sspc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ByteTarget = 1900;
  localparam int QuietTail  = 300;
  localparam int CycleLimit = 400000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [ByteW-1:0]    s_tdata = '0;
  logic                s_tlast = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;

  int mismatches;
  int outstanding;
  int cycle_count = 0;
  bit idle_on = 1'b1;

  logic [ByteW-1:0] pkt[$];

  servo_status_packet_checker dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  servo_reply_monitor monitor (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("** servo_status_packet_checker: FAILED **");
      $finish;
    end
  end

  // Stall the reply side in random bursts while idling is enabled
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // Present one byte and hold it until the transfer happens
  task automatic send_byte(input logic [ByteW-1:0] b, input logic last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_packet();
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  // Recompute the trailing checksum over bytes 2 through n-2
  task automatic seal_checksum();
    logic [ByteW-1:0] sum;
    sum = '0;
    for (int i = 2; i < pkt.size() - 1; i++) sum = sum + pkt[i];
    pkt[pkt.size() - 1] = ~sum;
  endtask

  // Build a well-formed reply with the given id, error byte and parameter count
  task automatic form_reply(input logic [ByteW-1:0] id, input logic [ByteW-1:0] err,
                            input int nparam);
    pkt.delete();
    pkt.push_back(HdrMark);
    pkt.push_back(HdrMark);
    pkt.push_back(id);
    pkt.push_back(ByteW'(nparam + 2));
    pkt.push_back(err);
    repeat (nparam) pkt.push_back(ByteW'($urandom));
    pkt.push_back('0);
    seal_checksum();
  endtask

  initial begin
    int sent;
    int kind;
    int cut;
    int pos;
    bit long_done;
    sent      = 0;
    long_done = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: one-byte packet, clean reply, then each failing check
    pkt = '{8'h00};
    send_packet();
    form_reply(8'hFF, 8'h00, 0);
    send_packet();
    form_reply(8'h01, 8'h00, 0);
    pkt[1] = 8'h7F;
    send_packet();
    form_reply(8'h80, 8'h00, 0);
    pkt[5] = pkt[5] ^ 8'h01;
    send_packet();
    form_reply(8'h2A, 8'h00, 1);
    pkt[3] = 8'd2;
    seal_checksum();
    send_packet();
    form_reply(8'h55, 8'hFF, 0);
    send_packet();

    // Random: mostly well-formed replies, some broken, some noise
    while (sent < ByteTarget) begin
      if (sent > ByteTarget - QuietTail)
        idle_on = 1'b0;
      else if ($urandom_range(0, 7) == 0)
        idle_on = !idle_on;
      kind = $urandom_range(0, 19);
      if (!long_done && sent > ByteTarget / 2) begin
        // Saturating byte count with a valid checksum
        form_reply(8'($urandom), 8'h00, 509 + $urandom_range(0, 4));
        long_done = 1'b1;
      end else if (kind <= 11) begin
        form_reply(8'($urandom), ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00,
                   ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6));
      end else if (kind <= 13) begin
        form_reply(8'($urandom), 8'h00, $urandom_range(0, 6));
        pos = $urandom_range(0, 1);
        pkt[pos] = pkt[pos] ^ 8'($urandom_range(1, 255));
      end else if (kind <= 15) begin
        form_reply(8'($urandom), 8'h00, $urandom_range(0, 6));
        pkt[pkt.size() - 1] = pkt[pkt.size() - 1] ^ 8'($urandom_range(1, 255));
      end else if (kind == 16) begin
        form_reply(8'($urandom), 8'h00, $urandom_range(0, 6));
        pkt[3] = pkt[3] ^ 8'($urandom_range(1, 255));
        seal_checksum();
      end else if (kind == 17) begin
        form_reply(8'($urandom), 8'($urandom), $urandom_range(0, 6));
        cut = $urandom_range(1, 5);
        while (pkt.size() > cut) void'(pkt.pop_back());
      end else begin
        pkt.delete();
        repeat ($urandom_range(1, 12)) pkt.push_back(8'($urandom));
      end
      send_packet();
      sent += pkt.size();
    end
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;

    // Drain outstanding replies, then settle
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("** servo_status_packet_checker: PASSED **");
    end else begin
      $display("** servo_status_packet_checker: FAILED **");
    end
    $finish;
  end

endmodule
